// ----- hdl/sal_pkg.sv -----
// Shared constants and operation codes for the sequential array list.
package sal_pkg;

	localparam int SAL_DEPTH = 64;
	localparam int VALUE_W   = 32;
	localparam int POS_W     = 7;
	localparam int MODE_W    = 3;

	typedef logic [MODE_W-1:0] mode_t;

	localparam mode_t MODE_INSERT = 3'd0;
	localparam mode_t MODE_DELETE = 3'd1;
	localparam mode_t MODE_LOCATE = 3'd2;
	localparam mode_t MODE_GET    = 3'd3;
	localparam mode_t MODE_CLEAR  = 3'd4;

endpackage

// ----- hdl/sal_req_if.sv -----
// Request channel: one list operation per word.
interface sal_req_if
	import sal_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [MODE_W-1:0]         mode;
	logic [POS_W-1:0]          position;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, mode, position, value, input ready);
	modport sink   (input valid, mode, position, value, output ready);
endinterface

// ----- hdl/sal_rsp_if.sv -----
// Response channel: one result word per operation.
interface sal_rsp_if
	import sal_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic                      status;
	logic signed [VALUE_W-1:0] read_value;
	logic [POS_W-1:0]          found_position;
	logic [POS_W-1:0]          list_length;
	logic                      is_empty;

	modport source (output valid, status, read_value, found_position, list_length, is_empty,
		input ready);
	modport sink   (input valid, status, read_value, found_position, list_length, is_empty,
		output ready);
endinterface

// ----- hdl/sal_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- hdl/sequential_array_list.sv -----
// Top level of the sequential array list: sequencer around one element RAM.
//
// Usage
//   req carries one operation per word (insert, delete, locate, get, clear)
//   with a 1-based position and a signed 32-bit value. rsp returns exactly one
//   word per request: status, read value, found position, new length, empty.
//   req.ready is high only while the sequencer is idle; one operation is in
//   flight at a time.
// Walk
//   Clear, rejected and unknown operations skip the walk; get reads one element.
//   Insert moves (length - position + 1) elements, delete (length - position),
//   locate reads up to length elements and stops at the first match. The RAM's
//   single read port walks one element per cycle; reads and write-backs overlap.
// Reset
//   arst_n clears the length, the sequencer and the response valid. The RAM is
//   not cleared: only entries below the length are ever read.
// Backpressure
//   The response sits in an output register. A new request is taken while it
//   waits; a finished result then holds in the sequencer until rsp is free.
module sequential_array_list
	import sal_pkg::*;
#(
	parameter int DEPTH = SAL_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	sal_req_if.sink   req,
	sal_rsp_if.source rsp
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]          state_q;
	logic [CW-1:0]       cnt_q;
	mode_t               op_q;
	logic [XW-1:0]       pos_q;
	logic [VALUE_W-1:0]  val_q;
	logic [AW-1:0]       rd_addr_q;
	logic [CW-1:0]       rem_q;
	logic                hit_q;
	logic                pend_s1;
	logic [AW-1:0]       addr_s1;

	// result held by the sequencer
	logic                res_status_q;
	logic [VALUE_W-1:0]  res_read_q;
	logic [POS_W-1:0]    res_found_q;

	// output register
	logic                out_valid_q;
	logic                out_status_q;
	logic [VALUE_W-1:0]  out_read_q;
	logic [POS_W-1:0]    out_found_q;
	logic [POS_W-1:0]    out_len_q;
	logic                out_empty_q;

	// RAM port signals
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [VALUE_W-1:0]  ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [VALUE_W-1:0]  ram_rdata;

	logic                accept;
	logic [XW-1:0]       pos_x;
	logic [XW-1:0]       cnt_x;
	logic                ins_ok;
	logic                pos_ok;
	logic                hit_now;
	logic                issue;
	logic                walk_done;
	logic                out_free;

	sal_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign pos_x  = XW'(req.position);
	assign cnt_x  = XW'(cnt_q);
	assign ins_ok = (cnt_x < XW'(DEPTH)) && (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
	assign pos_ok = (pos_x != '0) && (pos_x <= cnt_x);

	// Locate stops at the first match: the hit holds off the next read.
	assign hit_now   = pend_s1 && (op_q == MODE_LOCATE) && !hit_q && (ram_rdata == val_q);
	assign issue     = (state_q == S_WALK) && (rem_q != '0) && !hit_now;
	assign walk_done = (state_q == S_WALK) && (rem_q == '0) && !pend_s1;

	assign ram_re    = issue;
	assign ram_raddr = rd_addr_q;

	// Write-back: shifted element from the read issued the cycle before, or the new value
	// once an insert has opened its slot.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = ram_rdata;
		if (pend_s1 && (op_q == MODE_INSERT)) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(addr_s1 + AW'(1));
		end else if (pend_s1 && (op_q == MODE_DELETE)) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(addr_s1 - AW'(1));
		end else if (walk_done && (op_q == MODE_INSERT)) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(pos_q - XW'(1));
			ram_wdata = val_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
			rem_q   <= '0;
			hit_q   <= 1'b0;
		end else begin
			pend_s1 <= issue;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						hit_q <= 1'b0;
						case (req.mode)
							MODE_INSERT: begin
								rem_q   <= CW'(cnt_x - pos_x + XW'(1));
								state_q <= ins_ok ? S_WALK : S_DONE;
							end
							MODE_DELETE: begin
								rem_q   <= CW'(cnt_x - pos_x);
								state_q <= pos_ok ? S_WALK : S_DONE;
							end
							MODE_LOCATE: begin
								rem_q   <= cnt_q;
								state_q <= S_WALK;
							end
							MODE_GET: begin
								rem_q   <= CW'(1);
								state_q <= pos_ok ? S_WALK : S_DONE;
							end
							MODE_CLEAR: begin
								cnt_q   <= '0;
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_WALK: begin
					if (hit_now) begin
						hit_q <= 1'b1;
						rem_q <= '0;
					end else if (issue) begin
						rem_q <= rem_q - CW'(1);
					end
					if (walk_done) begin
						if (op_q == MODE_INSERT) begin
							cnt_q <= cnt_q + CW'(1);
						end else if (op_q == MODE_DELETE) begin
							cnt_q <= cnt_q - CW'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Operation payload and walker address
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= req.mode;
			pos_q        <= pos_x;
			val_q        <= req.value;
			res_read_q   <= '0;
			res_found_q  <= '0;
			res_status_q <= 1'b0;
			case (req.mode)
				MODE_INSERT: begin
					rd_addr_q    <= AW'(cnt_x - XW'(1));
					res_status_q <= !ins_ok;
				end
				MODE_DELETE: begin
					rd_addr_q    <= AW'(pos_x);
					res_status_q <= !pos_ok;
				end
				MODE_LOCATE: begin
					rd_addr_q <= '0;
				end
				MODE_GET: begin
					rd_addr_q    <= AW'(pos_x - XW'(1));
					res_status_q <= !pos_ok;
				end
				MODE_CLEAR: begin
					rd_addr_q <= '0;
				end
				default: begin
					rd_addr_q    <= '0;
					res_status_q <= 1'b1;
				end
			endcase
		end else begin
			if (issue) begin
				addr_s1 <= rd_addr_q;
				// insert walks down from the tail, all others walk up
				if (op_q == MODE_INSERT) begin
					rd_addr_q <= rd_addr_q - AW'(1);
				end else begin
					rd_addr_q <= rd_addr_q + AW'(1);
				end
			end
			if (hit_now) begin
				res_found_q <= POS_W'({1'b0, addr_s1} + (AW + 1)'(1));
			end
			if (pend_s1 && (op_q == MODE_GET)) begin
				res_read_q <= ram_rdata;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_read_q   <= res_read_q;
			out_found_q  <= res_found_q;
			out_len_q    <= POS_W'(cnt_x);
			out_empty_q  <= (cnt_q == '0);
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.read_value     = out_read_q;
	assign rsp.found_position = out_found_q;
	assign rsp.list_length    = out_len_q;
	assign rsp.is_empty       = out_empty_q;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("element count exceeds depth");

	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("RAM read and write hit the same entry");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(walk_done && op_q == MODE_INSERT) |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("insert did not grow the list");

	a_pend_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == S_WALK))
		else $error("read in flight outside the walk");
endmodule
